>>> hdl/fwh_pkg.sv
// Shared types, widths and reset values of the fixed-width histogram.
package fwh_pkg;

  // Bucket store geometry and field widths.
  localparam int MAX_BUCKETS = 64;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int NUSE_W      = BKT_W + 1;
  localparam int BCFG_W      = 7;
  localparam int SAMPLE_W    = 32;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 64;
  localparam int MEAN_W      = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = SAMPLE_W + BKT_W;
  localparam int DSTEP_W     = $clog2(BKT_W);
  localparam int MSTEP_W     = $clog2(MEAN_W);

  // Reset values of the configuration registers.
  localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST  = SAMPLE_W'(0);
  localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST = SAMPLE_W'(1000000);
  localparam logic [BCFG_W-1:0]          BUCKETS_RST    = BCFG_W'(64);

  // Saturation limits.
  localparam logic [CNT_W-1:0]          CNT_MAX  = '1;
  localparam logic signed [SUM_W-1:0]   SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [MEAN_W-1:0]  MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0]  MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  // Item kinds.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_BUCKETS    = 2'd2
  } cfg_reg_e;

  // One input item.
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BKT_W-1:0]           read_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                       is_outlier;
    logic [BKT_W-1:0]           bucket_index;
    logic [CNT_W-1:0]           bucket_value;
    logic signed [SAMPLE_W-1:0] min_seen;
    logic signed [SAMPLE_W-1:0] max_seen;
    logic [CNT_W-1:0]           total_count;
    logic signed [SUM_W-1:0]    sample_sum;
    logic [CNT_W-1:0]           outlier_count;
    logic signed [MEAN_W-1:0]   mean_value;
  } out_item_t;

endpackage

>>> hdl/fwh_mean_div.sv
// Bit-serial divider that turns the running sum and count into the truncated mean.
module fwh_mean_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [fwh_pkg::SUM_W-1:0]   sum_i,
  input  logic [fwh_pkg::CNT_W-1:0]          count_i,
  output logic                               done_o,
  output logic signed [fwh_pkg::MEAN_W-1:0]  mean_o
);

  logic                              busy_q;
  logic                              fin_q;
  logic                              done_q;
  logic signed [fwh_pkg::MEAN_W-1:0] mean_q;
  logic                              neg_q;
  logic [fwh_pkg::CNT_W-1:0]         rem_q;
  logic [fwh_pkg::MEAN_W-1:0]        lo_q;
  logic [fwh_pkg::MEAN_W-1:0]        quo_q;
  logic [fwh_pkg::CNT_W-1:0]         div_q;
  logic [fwh_pkg::MSTEP_W-1:0]       step_q;

  logic [fwh_pkg::SUM_W-1:0]         mag;
  logic                              ovf;
  logic [fwh_pkg::CNT_W:0]           trial;
  logic [fwh_pkg::CNT_W:0]           diff;
  logic                              ge;
  logic                              last_step;
  logic signed [fwh_pkg::MEAN_W-1:0] sat_res;

  // Magnitude of the sum; a quotient of 2^32 or more is known from the high half alone.
  assign mag = sum_i[fwh_pkg::SUM_W-1] ? (~sum_i + fwh_pkg::SUM_W'(1)) : sum_i;
  assign ovf = mag[fwh_pkg::SUM_W-1:fwh_pkg::MEAN_W] >= count_i;

  // One restoring step per cycle.
  assign trial = {rem_q, lo_q[fwh_pkg::MEAN_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  assign last_step = step_q == fwh_pkg::MSTEP_W'(fwh_pkg::MEAN_W - 1);

  // Apply the sign and clamp to the signed 32-bit limits.
  always_comb begin
    if (neg_q) begin
      if (quo_q > fwh_pkg::MEAN_MIN) begin
        sat_res = fwh_pkg::MEAN_MIN;
      end else begin
        sat_res = ~quo_q + fwh_pkg::MEAN_W'(1);
      end
    end else if (quo_q[fwh_pkg::MEAN_W-1]) begin
      sat_res = fwh_pkg::MEAN_MAX;
    end else begin
      sat_res = quo_q;
    end
  end

  // Sequencing and the held mean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      mean_q <= '0;
    end else begin
      done_q <= (start_i && ovf) || (!start_i && !busy_q && fin_q);
      fin_q  <= !start_i && busy_q && last_step;
      if (start_i) begin
        step_q <= '0;
        if (ovf) begin
          mean_q <= sum_i[fwh_pkg::SUM_W-1] ? fwh_pkg::MEAN_MIN : fwh_pkg::MEAN_MAX;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + fwh_pkg::MSTEP_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end else if (fin_q) begin
        mean_q <= sat_res;
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[fwh_pkg::SUM_W-1];
      div_q <= count_i;
      rem_q <= mag[fwh_pkg::SUM_W-1:fwh_pkg::MEAN_W];
      lo_q  <= mag[fwh_pkg::MEAN_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[fwh_pkg::CNT_W-1:0] : trial[fwh_pkg::CNT_W-1:0];
      lo_q  <= {lo_q[fwh_pkg::MEAN_W-2:0], 1'b0};
      quo_q <= {quo_q[fwh_pkg::MEAN_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

  // A new division never starts over one that is still running.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!busy_q && !fin_q))
    else $error("mean division started while busy");

  // Completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("mean done held longer than one cycle");

  // A non-negative sum never yields a negative mean.
  a_pos_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !neg_q && !$past(start_i)) |-> !mean_q[fwh_pkg::MEAN_W-1])
    else $error("negative mean from a non-negative sum");

endmodule

>>> hdl/fixed_width_histogram.sv
// Fixed-width bin histogram: bucket store, running statistics and result register.
//
//   channel  signals                               direction
//   in       in_valid_i, in_stall_o, in_data_i     item in: add a sample or read a bucket
//   out      out_valid_o, out_stall_i, out_data_o  result item with bucket and statistics
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i       range_low, range_high, bucket_count
//
// One item is worked at a time. An outlier goes straight to the result, and a bucket read
// only reads the store. An in-range sample passes the bucket division (one quotient bit
// a cycle), the bucket store read and write-back, and the bit-serial mean divider, which
// takes longest.
// The next item is taken while the previous result still waits at the output.
// Reset sets the statistics, the bucket valid bits and the configuration registers at once.
module fixed_width_histogram (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fwh_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fwh_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [fwh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fwh_pkg::CFG_W-1:0]          cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_MEAN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [fwh_pkg::SAMPLE_W-1:0] low_q;
  logic signed [fwh_pkg::SAMPLE_W-1:0] high_q;
  logic [fwh_pkg::BCFG_W-1:0]          bc_q;

  // Running statistics.
  logic signed [fwh_pkg::SAMPLE_W-1:0] min_q;
  logic signed [fwh_pkg::SAMPLE_W-1:0] max_q;
  logic [fwh_pkg::CNT_W-1:0]           total_q;
  logic signed [fwh_pkg::SUM_W-1:0]    sum_q;
  logic [fwh_pkg::CNT_W-1:0]           outl_q;

  // Bucket store with one valid bit per entry.
  logic [fwh_pkg::CNT_W-1:0]           mem_q [fwh_pkg::MAX_BUCKETS];
  logic [fwh_pkg::MAX_BUCKETS-1:0]     bvld_q;
  logic [fwh_pkg::CNT_W-1:0]           rdata_q;
  logic                                rvld_q;

  // Per-item working registers.
  fwh_pkg::in_item_t                   item_q;
  logic [fwh_pkg::SAMPLE_W-1:0]        num_q;
  logic [fwh_pkg::SAMPLE_W-1:0]        den_q;
  logic [fwh_pkg::PROD_W-1:0]          rem_q;
  logic [fwh_pkg::PROD_W-1:0]          dsh_q;
  logic [fwh_pkg::DSTEP_W-1:0]         dstep_q;
  logic [fwh_pkg::BKT_W-1:0]           addr_q;
  logic                                flag_q;
  logic [fwh_pkg::CNT_W-1:0]           bval_q;
  logic                                div_start_q;

  // Result register.
  fwh_pkg::out_item_t                  out_q;
  logic                                out_vld_q;

  logic [fwh_pkg::NUSE_W-1:0]          n_use;
  logic [fwh_pkg::BKT_W-1:0]           last_bkt;
  logic                                in_range;
  logic                                at_high;
  logic                                ge;
  logic [fwh_pkg::CNT_W-1:0]           cur;
  logic [fwh_pkg::CNT_W-1:0]           cur_inc;
  logic signed [fwh_pkg::SUM_W-1:0]    sx;
  logic signed [fwh_pkg::SUM_W:0]      sum_ext;
  logic signed [fwh_pkg::SUM_W-1:0]    sum_sat;
  logic                                out_free;
  logic                                mem_we;
  logic                                div_done;
  logic signed [fwh_pkg::MEAN_W-1:0]   mean;

  // Buckets in use: zero means one, anything above the store means the store size.
  always_comb begin
    if (bc_q == '0) begin
      n_use = fwh_pkg::NUSE_W'(1);
    end else if (fwh_pkg::NUSE_W'(bc_q) > fwh_pkg::NUSE_W'(fwh_pkg::MAX_BUCKETS)) begin
      n_use = fwh_pkg::NUSE_W'(fwh_pkg::MAX_BUCKETS);
    end else begin
      n_use = fwh_pkg::NUSE_W'(bc_q);
    end
  end
  assign last_bkt = fwh_pkg::BKT_W'(n_use - fwh_pkg::NUSE_W'(1));

  // Range check of the held sample.
  assign in_range = (item_q.sample >= low_q) && (item_q.sample <= high_q);
  assign at_high  = item_q.sample == high_q;

  // Quotient step: the shifted divisor is compared once per cycle.
  assign ge = rem_q >= dsh_q;

  // Read-modify-write of one bucket; an entry never written reads as zero.
  assign cur     = rvld_q ? rdata_q : '0;
  assign cur_inc = (cur == fwh_pkg::CNT_MAX) ? cur : cur + fwh_pkg::CNT_W'(1);
  assign mem_we  = (state_q == S_UPD) && (item_q.kind == fwh_pkg::KIND_ADD);

  // Saturating sum update.
  assign sx      = fwh_pkg::SUM_W'(item_q.sample);
  assign sum_ext = {sum_q[fwh_pkg::SUM_W-1], sum_q} + {sx[fwh_pkg::SUM_W-1], sx};
  always_comb begin
    if (sum_ext[fwh_pkg::SUM_W] != sum_ext[fwh_pkg::SUM_W-1]) begin
      sum_sat = sum_ext[fwh_pkg::SUM_W] ? fwh_pkg::SUM_MIN : fwh_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_ext[fwh_pkg::SUM_W-1:0];
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  // Mean of the running statistics, refreshed after each in-range sample.
  fwh_mean_div u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .sum_i   (sum_q),
    .count_i (total_q),
    .done_o  (div_done),
    .mean_o  (mean)
  );

  // Sequencer, configuration, statistics and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_q       <= fwh_pkg::RANGE_LOW_RST;
      high_q      <= fwh_pkg::RANGE_HIGH_RST;
      bc_q        <= fwh_pkg::BUCKETS_RST;
      min_q       <= fwh_pkg::RANGE_HIGH_RST;
      max_q       <= fwh_pkg::RANGE_LOW_RST;
      total_q     <= '0;
      sum_q       <= '0;
      outl_q      <= '0;
      bvld_q      <= '0;
      div_start_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      // The mean division starts right after a sample updates the statistics.
      div_start_q <= mem_we;
      if (out_vld_q && !out_stall_i && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fwh_pkg::REG_RANGE_LOW:  low_q  <= cfg_data_i;
          fwh_pkg::REG_RANGE_HIGH: high_q <= cfg_data_i;
          fwh_pkg::REG_BUCKETS:    bc_q   <= cfg_data_i[fwh_pkg::BCFG_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (item_q.kind == fwh_pkg::KIND_READ) begin
            state_q <= S_RD;
          end else if (!in_range) begin
            if (outl_q != fwh_pkg::CNT_MAX) begin
              outl_q <= outl_q + fwh_pkg::CNT_W'(1);
            end
            state_q <= S_DONE;
          end else if (at_high) begin
            state_q <= S_RD;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dstep_q == fwh_pkg::DSTEP_W'(fwh_pkg::BKT_W - 1)) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (item_q.kind == fwh_pkg::KIND_ADD) begin
            bvld_q[addr_q] <= 1'b1;
            if (item_q.sample < min_q) begin
              min_q <= item_q.sample;
            end
            if (item_q.sample > max_q) begin
              max_q <= item_q.sample;
            end
            if (total_q != fwh_pkg::CNT_MAX) begin
              total_q <= total_q + fwh_pkg::CNT_W'(1);
            end
            sum_q   <= sum_sat;
            state_q <= S_MEAN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end

    case (state_q)
      S_PREP: begin
        num_q  <= item_q.sample - low_q;
        den_q  <= high_q - low_q;
        flag_q <= (item_q.kind == fwh_pkg::KIND_ADD) && !in_range;
        if (item_q.kind == fwh_pkg::KIND_READ) begin
          addr_q <= item_q.read_index;
        end else if (!in_range) begin
          addr_q <= '0;
          bval_q <= '0;
        end else begin
          addr_q <= last_bkt;
        end
      end
      S_MUL: begin
        // Quotient is below the bucket count, since the offset is below the width.
        rem_q   <= fwh_pkg::PROD_W'(num_q) * fwh_pkg::PROD_W'(n_use);
        dsh_q   <= fwh_pkg::PROD_W'(den_q) << (fwh_pkg::BKT_W - 1);
        dstep_q <= '0;
        addr_q  <= '0;
      end
      S_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q   <= dsh_q >> 1;
        dstep_q <= dstep_q + fwh_pkg::DSTEP_W'(1);
        addr_q  <= {addr_q[fwh_pkg::BKT_W-2:0], ge};
      end
      S_RD: begin
        rdata_q <= mem_q[addr_q];
        rvld_q  <= bvld_q[addr_q];
      end
      S_UPD: begin
        bval_q <= (item_q.kind == fwh_pkg::KIND_ADD) ? cur_inc : cur;
      end
      default: ;
    endcase

    if (mem_we) begin
      mem_q[addr_q] <= cur_inc;
    end

    if (state_q == S_DONE && out_free) begin
      out_q.is_outlier    <= flag_q;
      out_q.bucket_index  <= addr_q;
      out_q.bucket_value  <= bval_q;
      out_q.min_seen      <= min_q;
      out_q.max_seen      <= max_q;
      out_q.total_count   <= total_q;
      out_q.sample_sum    <= sum_q;
      out_q.outlier_count <= outl_q;
      out_q.mean_value    <= mean;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Only a sample item ever writes the bucket store.
  a_we_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (item_q.kind == fwh_pkg::KIND_ADD && !flag_q))
    else $error("bucket store written by a read or outlier item");

  // The in-range count never decreases.
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("in-range count went down");

  // The mean divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_MEAN)
    else $error("mean divider finished outside its wait state");

  // A result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_vld_q && out_stall_i) |=> state_q == S_DONE)
    else $error("result overwritten while still waiting");

endmodule

>>> verif/tb_fixed_width_histogram.sv
// Self-checking testbench of the fixed-width bin histogram: random items, stalls and settings.
module tb_fixed_width_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;

  // Clock, reset and the ports of the block.
  logic                          clk_i = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  fwh_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fwh_pkg::out_item_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [fwh_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [fwh_pkg::CFG_W-1:0]     cfg_data = '0;

  // Items waiting to be sent and results waiting to arrive.
  fwh_pkg::in_item_t  pending_items[$];
  fwh_pkg::out_item_t expected_results[$];

  // Idle rate shared by both sides, a gap count per side, mismatch and cycle counts.
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Histogram state as the testbench sees it.
  logic [fwh_pkg::CNT_W-1:0]           bucket_tally [fwh_pkg::MAX_BUCKETS] = '{default: '0};
  logic signed [fwh_pkg::SAMPLE_W-1:0] lowest_in   = fwh_pkg::RANGE_HIGH_RST;
  logic signed [fwh_pkg::SAMPLE_W-1:0] highest_in  = fwh_pkg::RANGE_LOW_RST;
  logic [fwh_pkg::CNT_W-1:0]           in_range_n  = '0;
  logic [fwh_pkg::CNT_W-1:0]           outlier_n   = '0;
  logic signed [fwh_pkg::SUM_W-1:0]    sum_in      = '0;
  logic signed [fwh_pkg::SAMPLE_W-1:0] cfg_low     = fwh_pkg::RANGE_LOW_RST;
  logic signed [fwh_pkg::SAMPLE_W-1:0] cfg_high    = fwh_pkg::RANGE_HIGH_RST;
  logic [fwh_pkg::BCFG_W-1:0]          cfg_buckets = fwh_pkg::BUCKETS_RST;

  fixed_width_histogram DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one item to the histogram state and returns the result it should produce.
  function automatic fwh_pkg::out_item_t predict_histogram(fwh_pkg::in_item_t item);
    fwh_pkg::out_item_t r;
    longint    v;
    longint    num;
    longint    den;
    longint    q;
    int        n;
    int        b;
    r = '0;
    if (item.kind == fwh_pkg::KIND_ADD) begin
      v = longint'($signed(item.sample));
      if (v < longint'(cfg_low) || v > longint'(cfg_high)) begin
        r.is_outlier = 1'b1;
        if (outlier_n != fwh_pkg::CNT_MAX) outlier_n++;
      end else begin
        if (cfg_buckets == '0) begin
          n = 1;
        end else if (int'(cfg_buckets) > fwh_pkg::MAX_BUCKETS) begin
          n = fwh_pkg::MAX_BUCKETS;
        end else begin
          n = int'(cfg_buckets);
        end
        // The top of the range always lands in the last bucket in use.
        if (v == longint'(cfg_high)) begin
          b = n - 1;
        end else begin
          num = v - longint'(cfg_low);
          den = longint'(cfg_high) - longint'(cfg_low);
          q = (num * n) / den;
          b = (q >= n) ? n - 1 : int'(q);
        end
        if (bucket_tally[b] != fwh_pkg::CNT_MAX) bucket_tally[b]++;
        r.bucket_index = b[fwh_pkg::BKT_W-1:0];
        r.bucket_value = bucket_tally[b];
        if (item.sample < lowest_in) lowest_in = item.sample;
        if (item.sample > highest_in) highest_in = item.sample;
        if (in_range_n != fwh_pkg::CNT_MAX) in_range_n++;
        // Running sum saturates at the signed 64-bit limits.
        if (v > 0 && sum_in > fwh_pkg::SUM_MAX - v) sum_in = fwh_pkg::SUM_MAX;
        else if (v < 0 && sum_in < fwh_pkg::SUM_MIN - v) sum_in = fwh_pkg::SUM_MIN;
        else sum_in = sum_in + v;
      end
    end else begin
      r.bucket_index = item.read_index;
      r.bucket_value = bucket_tally[item.read_index];
    end
    r.min_seen      = lowest_in;
    r.max_seen      = highest_in;
    r.total_count   = in_range_n;
    r.sample_sum    = sum_in;
    r.outlier_count = outlier_n;
    // Truncated mean, clamped to the 32-bit signed limits.
    if (in_range_n == 0) begin
      r.mean_value = '0;
    end else begin
      q = sum_in / longint'({32'd0, in_range_n});
      if (q > longint'(fwh_pkg::MEAN_MAX)) q = longint'(fwh_pkg::MEAN_MAX);
      if (q < longint'(fwh_pkg::MEAN_MIN)) q = longint'(fwh_pkg::MEAN_MIN);
      r.mean_value = q[fwh_pkg::MEAN_W-1:0];
    end
    return r;
  endfunction

  function automatic fwh_pkg::in_item_t add_sample(logic signed [fwh_pkg::SAMPLE_W-1:0] v);
    fwh_pkg::in_item_t it;
    it.kind = fwh_pkg::KIND_ADD;
    it.sample = v;
    it.read_index = fwh_pkg::BKT_W'($urandom);
    return it;
  endfunction

  function automatic fwh_pkg::in_item_t read_bucket(logic [fwh_pkg::BKT_W-1:0] idx);
    fwh_pkg::in_item_t it;
    it.kind = fwh_pkg::KIND_READ;
    it.sample = fwh_pkg::SAMPLE_W'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // Random item biased toward the current range, its edges and just outside it.
  function automatic fwh_pkg::in_item_t random_item();
    fwh_pkg::in_item_t         it;
    int                        pick;
    logic [fwh_pkg::CFG_W-1:0] span;
    it = add_sample(fwh_pkg::SAMPLE_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it = read_bucket(fwh_pkg::BKT_W'($urandom));
    end else if (pick < 30) begin
      it.sample = fwh_pkg::SAMPLE_W'($urandom);
    end else if (pick < 36) begin
      it.sample = cfg_low;
    end else if (pick < 42) begin
      it.sample = cfg_high;
    end else if (pick < 46) begin
      it.sample = cfg_low - 1;
    end else if (pick < 50) begin
      it.sample = cfg_high + 1;
    end else if (cfg_low <= cfg_high) begin
      span = cfg_high - cfg_low;
      it.sample = cfg_low + fwh_pkg::SAMPLE_W'($urandom_range(0, span));
    end
    return it;
  endfunction

  // Register write; the testbench copy follows at once since the block is idle.
  task automatic write_reg(fwh_pkg::cfg_reg_e which, logic [fwh_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= which;
    cfg_data <= value;
    case (which)
      fwh_pkg::REG_RANGE_LOW:  cfg_low = value;
      fwh_pkg::REG_RANGE_HIGH: cfg_high = value;
      fwh_pkg::REG_BUCKETS:    cfg_buckets = value[fwh_pkg::BCFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic signed [fwh_pkg::SAMPLE_W-1:0] lo,
                           logic signed [fwh_pkg::SAMPLE_W-1:0] hi,
                           logic [fwh_pkg::BCFG_W-1:0] nbkt);
    write_reg(fwh_pkg::REG_RANGE_LOW, lo);
    write_reg(fwh_pkg::REG_RANGE_HIGH, hi);
    write_reg(fwh_pkg::REG_BUCKETS, {{(fwh_pkg::CFG_W-fwh_pkg::BCFG_W){1'b0}}, nbkt});
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random settings: full span, equal bounds, reversed, narrow or arbitrary ranges.
  task automatic random_config();
    logic signed [fwh_pkg::SAMPLE_W-1:0] lo;
    logic signed [fwh_pkg::SAMPLE_W-1:0] hi;
    logic signed [fwh_pkg::SAMPLE_W-1:0] tmp;
    logic [fwh_pkg::BCFG_W-1:0]          nbkt;
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        lo = {1'b1, {(fwh_pkg::SAMPLE_W-1){1'b0}}};
        hi = {1'b0, {(fwh_pkg::SAMPLE_W-1){1'b1}}};
      end
      1: hi = lo;
      2: begin
        lo = $signed($urandom) >>> 1;
        hi = lo - $urandom_range(1, 1000);
      end
      3, 4, 5: begin
        lo = $signed($urandom) >>> 1;
        hi = lo + $urandom_range(1, 300);
      end
      default: begin
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    case ($urandom_range(0, 7))
      0: nbkt = '0;
      1: nbkt = '1;
      2: nbkt = fwh_pkg::BCFG_W'(fwh_pkg::MAX_BUCKETS);
      3: nbkt = fwh_pkg::BCFG_W'(1);
      4: nbkt = fwh_pkg::BCFG_W'($urandom_range(fwh_pkg::MAX_BUCKETS + 1, 127));
      default: nbkt = fwh_pkg::BCFG_W'($urandom_range(1, fwh_pkg::MAX_BUCKETS));
    endcase
    configure(lo, hi, nbkt);
  endtask

  // Waits until every item is sent and every result is back, then lets the block go quiet.
  // The queues are looked at between edges, where the driver's updates have all landed.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [fwh_pkg::SUM_W-1:0] want,
                             logic [fwh_pkg::SUM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: holds a stalled item, otherwise sends the next one or idles.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_histogram(in_data));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          in_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each accepted result and drives random stall bursts.
  always @(posedge clk_i) begin
    fwh_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("is_outlier", want.is_outlier, out_data.is_outlier);
          check_field("bucket_index", want.bucket_index, out_data.bucket_index);
          check_field("bucket_value", want.bucket_value, out_data.bucket_value);
          check_field("min_seen", want.min_seen, out_data.min_seen);
          check_field("max_seen", want.max_seen, out_data.max_seen);
          check_field("total_count", want.total_count, out_data.total_count);
          check_field("sample_sum", want.sample_sum, out_data.sample_sum);
          check_field("outlier_count", want.outlier_count, out_data.outlier_count);
          check_field("mean_value", want.mean_value, out_data.mean_value);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("fixed_width_histogram regression: fail");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    idle_pct = 20;

    // Reset settings: cleared store, range edges, outliers and the first bucket boundary.
    pending_items.push_back(read_bucket(6'd0));
    pending_items.push_back(read_bucket(6'd63));
    pending_items.push_back(add_sample(0));
    pending_items.push_back(add_sample(1000000));
    pending_items.push_back(add_sample(-1));
    pending_items.push_back(add_sample(1000001));
    pending_items.push_back(add_sample(32'h7FFF_FFFF));
    pending_items.push_back(add_sample(32'h8000_0000));
    pending_items.push_back(add_sample(15624));
    pending_items.push_back(add_sample(15625));
    pending_items.push_back(add_sample(999999));
    pending_items.push_back(read_bucket(6'd0));
    pending_items.push_back(read_bucket(6'd1));
    settle();

    // Full 32-bit span with a single bucket.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd1);
    pending_items.push_back(add_sample(32'h8000_0000));
    pending_items.push_back(add_sample(32'h7FFF_FFFF));
    pending_items.push_back(add_sample(0));
    pending_items.push_back(read_bucket(6'd0));
    settle();

    // Equal bounds with a zero bucket count.
    configure(5, 5, 7'd0);
    pending_items.push_back(add_sample(5));
    pending_items.push_back(add_sample(4));
    pending_items.push_back(add_sample(6));
    settle();

    // Reversed bounds with a bucket count above the store size.
    configure(10, -10, 7'd127);
    pending_items.push_back(add_sample(0));
    pending_items.push_back(add_sample(10));
    pending_items.push_back(add_sample(-10));
    settle();

    // Random phases, each under new settings and its own idle rate.
    for (int p = 0; p < 8; p++) begin
      random_config();
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      for (int i = 0; i < 55; i++) pending_items.push_back(random_item());
      settle();
    end

    // Closing phase at full rate under the reset settings.
    configure(fwh_pkg::RANGE_LOW_RST, fwh_pkg::RANGE_HIGH_RST, fwh_pkg::BUCKETS_RST);
    idle_pct = 0;
    for (int i = 0; i < 60; i++) pending_items.push_back(random_item());
    settle();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fixed_width_histogram regression: pass");
    end else begin
      $display("fixed_width_histogram regression: fail");
    end
    $finish;
  end

endmodule
